// ===== sv/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo channel curve mapper package
// Shared widths, register indexes, conversion constants and the word types
// that travel between the front stage, the divider cells and the tail.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int X_W     = 11;
    localparam int PT_W    = 12;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 3;
    localparam int QUO_W   = 12;
    localparam int REM_W   = 23;
    localparam int SUM_W   = 14;
    localparam int PULSE_W = 16;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;

    localparam int OPT_INVERT = 0;
    localparam int OPT_NARROW = 1;

    localparam int CENTER_US = 1500;
    localparam int CH_IN_LO  = 172;
    localparam int CH_IN_HI  = 1811;
    localparam int US_OUT_LO = 988;

    // The doubled output span of the plain conversion is 2048, a shift by 11.
    localparam int PLAIN_SHIFT = 11;

    localparam logic [X_W-1:0]     PLAIN_IN_LO  = X_W'(CH_IN_LO);
    localparam logic [PT_W-1:0]    PLAIN_DIV    = PT_W'(CH_IN_HI - CH_IN_LO);
    localparam logic [PT_W-1:0]    PLAIN_BASE   = PT_W'(US_OUT_LO * 2 + 1);
    localparam logic [PULSE_W-1:0] CENTER_TWICE = PULSE_W'(2 * CENTER_US);

    typedef enum logic [IDX_W-1:0] {
        REG_MAP_MODE  = 3'd0,
        REG_IN_ONE    = 3'd1,
        REG_IN_TWO    = 3'd2,
        REG_IN_THREE  = 3'd3,
        REG_OUT_ONE   = 3'd4,
        REG_OUT_TWO   = 3'd5,
        REG_OUT_THREE = 3'd6,
        REG_OPTIONS   = 3'd7
    } scm_reg_idx_t;

    typedef struct packed {
        logic [1:0]       map_mode;
        logic [CFG_W-1:0] in_point_one;
        logic [CFG_W-1:0] in_point_two;
        logic [CFG_W-1:0] in_point_three;
        logic [CFG_W-1:0] out_point_one;
        logic [CFG_W-1:0] out_point_two;
        logic [CFG_W-1:0] out_point_three;
        logic [1:0]       output_options;
    } scm_cfg_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic [PT_W-1:0]  base;
        logic             plain;
    } scm_word_t;

endpackage

// ===== sv/scm_front.sv =====
// ----------------------------------------------------------------------------
// Servo channel curve mapper front stage
// Selects the segment or level for one channel value and loads the dividend,
// the aligned divisor and the base value into the first pipeline word.
// ----------------------------------------------------------------------------
module scm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scm_pkg::scm_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [scm_pkg::X_W-1:0]       channel_value,
    output logic                          word_valid,
    output scm_pkg::scm_word_t            word,
    input  logic                          down_ready
);
    import scm_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    scm_word_t         word_reg;
    scm_word_t         word_next;
    logic              load;
    logic [PT_W-1:0]   xi;
    logic [PT_W-1:0]   i1;
    logic [PT_W-1:0]   i2;
    logic [PT_W-1:0]   i3;
    logic [PT_W-1:0]   o1;
    logic [PT_W-1:0]   o2;
    logic [PT_W-1:0]   o3;
    logic              seg_low;
    logic [PT_W-1:0]   xa;
    logic [PT_W-1:0]   xb;
    logic [PT_W-1:0]   ya;
    logic [PT_W-1:0]   yb;
    logic [PT_W-1:0]   dx_full;
    logic [X_W-1:0]    dx;
    logic [PT_W:0]     dy;
    logic [PT_W:0]     dy_abs;
    logic [PT_W-1:0]   span;
    logic [REM_W-1:0]  prod;
    logic              p_neg;
    logic [X_W-1:0]    p_mag;

    assign xi = {1'b0, channel_value};
    assign i1 = {cfg.in_point_one, 1'b0};
    assign i2 = {cfg.in_point_two, 1'b0};
    assign i3 = {cfg.in_point_three, 1'b0};
    assign o1 = {cfg.out_point_one, 1'b0};
    assign o2 = {cfg.out_point_two, 1'b0};
    assign o3 = {cfg.out_point_three, 1'b0};

    assign seg_low = (xi <= i2);
    assign xa      = seg_low ? i1 : i2;
    assign xb      = seg_low ? i2 : i3;
    assign ya      = seg_low ? o1 : o2;
    assign yb      = seg_low ? o2 : o3;

    // Inside a segment the value lies above its first breakpoint and at most
    // 2047 above it, so the difference fits the channel width.
    assign dx_full = xi - xa;
    assign dx      = dx_full[X_W-1:0];
    assign dy      = {1'b0, yb} - {1'b0, ya};
    assign dy_abs  = dy[PT_W] ? ((PT_W+1)'(0) - dy) : dy;
    assign span    = xb - xa;
    assign prod    = {{(REM_W-X_W){1'b0}}, dx} * {{(REM_W-PT_W){1'b0}}, dy_abs[PT_W-1:0]};

    assign p_neg = (channel_value < PLAIN_IN_LO);
    assign p_mag = p_neg ? (PLAIN_IN_LO - channel_value) : (channel_value - PLAIN_IN_LO);

    always_comb
    begin
        word_next.rem   = '0;
        word_next.dsh   = {PT_W'(1), {PLAIN_SHIFT{1'b0}}};
        word_next.quo   = '0;
        word_next.neg   = 1'b0;
        word_next.base  = o3;
        word_next.plain = 1'b0;
        if (cfg.map_mode == MODE_PLAIN)
        begin
            word_next.rem   = {1'b0, p_mag, {PLAIN_SHIFT{1'b0}}};
            word_next.dsh   = {PLAIN_DIV, {PLAIN_SHIFT{1'b0}}};
            word_next.neg   = p_neg;
            word_next.base  = PLAIN_BASE;
            word_next.plain = 1'b1;
        end
        else if (cfg.map_mode == MODE_STEP)
        begin
            if (xi < i2)
            begin
                word_next.base = o1;
            end
            else if (xi < i3)
            begin
                word_next.base = o2;
            end
            else
            begin
                word_next.base = o3;
            end
        end
        else
        begin
            if (xi <= i1)
            begin
                word_next.base = o1;
            end
            else if (xi >= i3)
            begin
                word_next.base = o3;
            end
            else if (span == '0)
            begin
                word_next.base = ya;
            end
            else
            begin
                word_next.rem  = prod;
                word_next.dsh  = {span, {PLAIN_SHIFT{1'b0}}};
                word_next.neg  = dy[PT_W];
                word_next.base = ya;
            end
        end
    end

    assign in_ready   = !valid_reg || down_ready;
    assign load       = in_ready && in_valid;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ===== sv/scm_cell.sv =====
// ----------------------------------------------------------------------------
// Servo channel curve mapper divider cell
// One restoring division step: compares the remainder with the aligned
// divisor, subtracts on success, shifts in one quotient bit and hands the
// word to the next cell with the divisor moved down one place.
// ----------------------------------------------------------------------------
module scm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  scm_pkg::scm_word_t   up_word,
    output logic                 down_valid,
    input  logic                 down_ready,
    output scm_pkg::scm_word_t   down_word
);
    import scm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    scm_word_t word_reg;
    scm_word_t word_next;
    logic      fits;
    logic      load;

    assign fits = (up_word.rem >= up_word.dsh);

    always_comb
    begin
        word_next     = up_word;
        word_next.rem = fits ? (up_word.rem - up_word.dsh) : up_word.rem;
        word_next.dsh = {1'b0, up_word.dsh[REM_W-1:1]};
        word_next.quo = {up_word.quo[QUO_W-2:0], fits};
    end

    assign up_ready   = !valid_reg || down_ready;
    assign load       = up_ready && up_valid;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_word  = word_reg;

endmodule

// ===== sv/scm_tail.sv =====
// ----------------------------------------------------------------------------
// Servo channel curve mapper tail stage
// Applies the sign to the quotient, adds the base, halves or clamps, then
// inverts and narrows as configured and holds the result word for output.
// ----------------------------------------------------------------------------
module scm_tail (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    output_options,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  scm_pkg::scm_word_t            up_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scm_pkg::PULSE_W-1:0]   pulse_us
);
    import scm_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [PULSE_W-1:0] pulse_reg;
    logic [PULSE_W-1:0] pulse_next;
    logic [SUM_W-1:0]   quo_ext;
    logic [SUM_W-1:0]   signed_quo;
    logic [SUM_W-1:0]   sum;
    logic [PULSE_W-1:0] mapped;
    logic [PULSE_W-1:0] inverted;
    logic               load;

    assign quo_ext    = {{(SUM_W-QUO_W){1'b0}}, up_word.quo};
    assign signed_quo = up_word.neg ? (SUM_W'(0) - quo_ext) : quo_ext;
    assign sum        = {{(SUM_W-PT_W){1'b0}}, up_word.base} + signed_quo;

    always_comb
    begin
        if (up_word.plain)
        begin
            mapped = {{(PULSE_W-SUM_W+1){1'b0}}, sum[SUM_W-1:1]};
        end
        else if (sum[SUM_W-1])
        begin
            mapped = '0;
        end
        else
        begin
            mapped = {{(PULSE_W-SUM_W){1'b0}}, sum};
        end
    end

    assign inverted   = output_options[OPT_INVERT] ? (CENTER_TWICE - mapped) : mapped;
    assign pulse_next = output_options[OPT_NARROW] ? {1'b0, inverted[PULSE_W-1:1]} : inverted;

    assign up_ready   = !valid_reg || !out_stall;
    assign load       = up_ready && up_valid;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pulse_reg <= pulse_next;
        end
    end

    assign out_valid = valid_reg;
    assign pulse_us  = pulse_reg;

endmodule

// ===== sv/servo_channel_curve_mapper.sv =====
// Each accepted channel word passes the front stage, the divider cells and the tail stage.
// Throughput: one word per cycle while out_stall is low; the row of 12 divider cells,
// one quotient bit each, sets the depth, and every stage moves on whenever the stage
// after it has room. Reset empties the pipeline and clears the configuration
// registers: plain conversion, no options.
// ----------------------------------------------------------------------------
// Servo channel curve mapper
// Maps one received channel value to a servo pulse width through a plain
// conversion, a three-level step or a three-point piecewise linear curve.
// ----------------------------------------------------------------------------
module servo_channel_curve_mapper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [scm_pkg::IDX_W-1:0]     cfg_index,
    input  logic [scm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scm_pkg::X_W-1:0]       channel_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scm_pkg::PULSE_W-1:0]   pulse_us
);
    import scm_pkg::*;

    scm_cfg_t   cfg_reg;
    scm_cfg_t   cfg_next;
    logic       front_ready;
    logic [QUO_W:0] chain_valid;
    logic [QUO_W:0] chain_ready;
    scm_word_t  chain_word [0:QUO_W];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (scm_reg_idx_t'(cfg_index))
                REG_MAP_MODE:  cfg_next.map_mode        = cfg_data[1:0];
                REG_IN_ONE:    cfg_next.in_point_one    = cfg_data;
                REG_IN_TWO:    cfg_next.in_point_two    = cfg_data;
                REG_IN_THREE:  cfg_next.in_point_three  = cfg_data;
                REG_OUT_ONE:   cfg_next.out_point_one   = cfg_data;
                REG_OUT_TWO:   cfg_next.out_point_two   = cfg_data;
                REG_OUT_THREE: cfg_next.out_point_three = cfg_data;
                REG_OPTIONS:   cfg_next.output_options  = cfg_data[1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (front_ready),
        .channel_value (channel_value),
        .word_valid    (chain_valid[0]),
        .word          (chain_word[0]),
        .down_ready    (chain_ready[0])
    );

    assign in_stall = !front_ready;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        scm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[i]),
            .up_ready   (chain_ready[i]),
            .up_word    (chain_word[i]),
            .down_valid (chain_valid[i+1]),
            .down_ready (chain_ready[i+1]),
            .down_word  (chain_word[i+1])
        );
    end

    scm_tail u_tail (
        .clk            (clk),
        .rst_n          (rst_n),
        .output_options (cfg_reg.output_options),
        .up_valid       (chain_valid[QUO_W]),
        .up_ready       (chain_ready[QUO_W]),
        .up_word        (chain_word[QUO_W]),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pulse_us       (pulse_us)
    );

`ifndef SYNTHESIS
    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |-> ({1'b0, chain_word[0].rem} < {chain_word[0].dsh, 1'b0}))
        else $error("Dividend too large for the quotient width.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("Input stalled while the pipeline had room.");

    a_curve_not_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[QUO_W] && !chain_word[QUO_W].plain && chain_word[QUO_W].neg)
        |-> (chain_word[QUO_W].quo <= chain_word[QUO_W].base))
        else $error("Interpolated value fell below zero.");
`endif

endmodule
